### src/box_non_maximum_suppression_unit_defines.svh
// assertion macros shared by the nms modules
`ifndef BOX_NON_MAXIMUM_SUPPRESSION_UNIT_DEFINES_SVH
`define BOX_NON_MAXIMUM_SUPPRESSION_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define NMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bnms_pkg.sv
package bnms_pkg;

  localparam int unsigned ScoreBits = 16;
  localparam int unsigned ThrBits   = 16;
  localparam logic [ThrBits-1:0] ThrReset = 16'h8000;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_MODE      = 1'b1
  } cfg_idx_e;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_WAITRD,
    ST_SWEEP,
    ST_EMIT
  } nms_state_e;

  // set boundary information passed from front to back
  typedef struct packed {
    logic [6:0] count;
    logic       overflow;
  } set_info_t;

endpackage

### src/box_non_maximum_suppression_unit.sv
// greedy box non-maximum suppression
// in channel: one candidate box per transaction (in_valid_i / in_ready_o); the
// box with last_box_i set closes the set and starts suppression. boxes past
// MaxBoxes are dropped and flagged on every result of that set.
// out channel: one transaction per kept box, in falling score order (ties in
// load order), kept_last_o on the final one, overflowed_o for dropped boxes.
// cfg channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i,
// index 0 threshold (Q0.16, reset 0.5), index 1 mode (0 iou, 1 min area).
// loading writes each accepted box straight into the store. suppression is
// sequential through the single read port of the box store: per kept box a
// scan pass over the n stored boxes, a fetch of the taken box, a sweep pass
// over them and an emit step, then a last scan and fetch that finds no live
// box before the next set.
// the front and back share the store, so the input stalls from the closing
// box until the back end is idle again. a stalled receiver holds the result
// register and the sequencer waits on it.
// reset clears all control state; the store needs no clearing pass.
module box_non_maximum_suppression_unit #(
  parameter int unsigned MAX_BOXES  = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] box_x_i,
  input  logic [COORD_BITS-1:0] box_y_i,
  input  logic [COORD_BITS-1:0] box_w_i,
  input  logic [COORD_BITS-1:0] box_h_i,
  input  logic [15:0]           box_score_i,
  input  logic                  last_box_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] kept_x_o,
  output logic [COORD_BITS-1:0] kept_y_o,
  output logic [COORD_BITS-1:0] kept_w_o,
  output logic [COORD_BITS-1:0] kept_h_o,
  output logic [15:0]           kept_score_o,
  output logic                  kept_last_o,
  output logic                  overflowed_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [0:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  localparam int unsigned IdxBits = $clog2(MAX_BOXES);
  localparam int unsigned EntBits = 4 * COORD_BITS + bnms_pkg::ScoreBits;

  logic [15:0] thr_q;
  logic        mode_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= bnms_pkg::ThrReset;
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (bnms_pkg::cfg_idx_e'(cfg_index_i))
        bnms_pkg::CFG_THRESHOLD: thr_q  <= cfg_data_i;
        bnms_pkg::CFG_MODE:      mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic                we;
  logic [IdxBits-1:0]  waddr, raddr;
  logic [EntBits-1:0]  wdata, rdata, oent;
  logic                set_valid, set_ready;
  bnms_pkg::set_info_t set_info;
  logic [MAX_BOXES-1:0] new_alive;

  // live mask for a fresh set: every stored entry
  always_comb begin
    for (int i = 0; i < MAX_BOXES; i++) begin
      new_alive[i] = (i < int'(set_info.count));
    end
  end

  bnms_front #(.MaxBoxes(MAX_BOXES), .CoordBits(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .entry_i({box_x_i, box_y_i, box_w_i, box_h_i, box_score_i}),
    .last_i(last_box_i), .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .set_valid_o(set_valid), .set_info_o(set_info), .set_ready_i(set_ready)
  );

  // two store halves would split sets; one store, front stalls on a pending set
  bnms_ram #(.Width(EntBits), .Depth(MAX_BOXES)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  bnms_back #(.MaxBoxes(MAX_BOXES), .CoordBits(COORD_BITS)) u_back (
    .clk_i, .rst_ni, .set_valid_i(set_valid), .set_info_i(set_info),
    .set_ready_o(set_ready), .raddr_o(raddr), .rdata_i(rdata),
    .thr_i(thr_q), .mode_i(mode_q), .new_alive_i(new_alive),
    .out_valid_o, .out_ready_i, .out_entry_o(oent),
    .out_last_o(kept_last_o), .out_ovf_o(overflowed_o)
  );

  assign {kept_x_o, kept_y_o, kept_w_o, kept_h_o, kept_score_o} = oent;

endmodule

### src/bnms_ram.sv
module bnms_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/bnms_front.sv
`include "box_non_maximum_suppression_unit_defines.svh"

module bnms_front #(
  parameter int unsigned MaxBoxes  = 64,
  parameter int unsigned CoordBits = 12,
  localparam int unsigned IdxBits  = $clog2(MaxBoxes),
  localparam int unsigned EntBits  = 4 * CoordBits + bnms_pkg::ScoreBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [EntBits-1:0]  entry_i,
  input  logic                last_i,
  output logic                we_o,
  output logic [IdxBits-1:0]  waddr_o,
  output logic [EntBits-1:0]  wdata_o,
  output logic                set_valid_o,
  output bnms_pkg::set_info_t set_info_o,
  input  logic                set_ready_i
);

  logic [IdxBits:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             full;
  logic             acc;

  // the queue to the back end holds one closed set
  logic                set_valid_q;
  bnms_pkg::set_info_t set_info_q;

  // the store is shared, so loading waits until the back end is idle
  assign full       = (count_q == (IdxBits+1)'(MaxBoxes));
  assign in_ready_o = !set_valid_q && set_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  assign we_o    = acc && !full;
  assign waddr_o = count_q[IdxBits-1:0];
  assign wdata_o = entry_i;

  // count and overflow tracking for the open set
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (acc) begin
      if (full) ovf_d = 1'b1;
      else count_d = count_q + 1'b1;
      if (last_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      set_valid_q <= 1'b0;
      set_info_q  <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (acc && last_i) begin
        set_valid_q         <= 1'b1;
        set_info_q.count    <= 7'(full ? count_q : count_q + 1'b1);
        set_info_q.overflow <= ovf_q || full;
      end else if (set_ready_i) begin
        set_valid_q <= 1'b0;
      end
    end
  end

  assign set_valid_o = set_valid_q;
  assign set_info_o  = set_info_q;

  `NMS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1,
    count_q <= (IdxBits+1)'(MaxBoxes), "box count beyond capacity")
  `NMS_ASSERT_IMP(a_no_write_full, clk_i, rst_ni, full, !we_o, "write into full store")
  `NMS_ASSERT_NEXT(a_set_closes, clk_i, rst_ni, acc && last_i,
    set_valid_q && count_q == '0, "set not handed over")

endmodule

### src/bnms_back.sv
`include "box_non_maximum_suppression_unit_defines.svh"

module bnms_back #(
  parameter int unsigned MaxBoxes  = 64,
  parameter int unsigned CoordBits = 12,
  localparam int unsigned IdxBits  = $clog2(MaxBoxes),
  localparam int unsigned EntBits  = 4 * CoordBits + bnms_pkg::ScoreBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 set_valid_i,
  input  bnms_pkg::set_info_t  set_info_i,
  output logic                 set_ready_o,
  output logic [IdxBits-1:0]   raddr_o,
  input  logic [EntBits-1:0]   rdata_i,
  input  logic [15:0]          thr_i,
  input  logic                 mode_i,
  input  logic [MaxBoxes-1:0]  new_alive_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [EntBits-1:0]   out_entry_o,
  output logic                 out_last_o,
  output logic                 out_ovf_o
);

  localparam int unsigned SB = bnms_pkg::ScoreBits;
  localparam int unsigned EB = CoordBits + 1;     // edge coordinate
  localparam int unsigned AB = 2 * CoordBits + 2; // areas and intersection

  bnms_pkg::nms_state_e st_q, st_d;

  logic [MaxBoxes-1:0] alive_q, alive_d;
  logic [IdxBits:0]    cnt_q;
  logic                ovf_q;
  logic [IdxBits:0]    ptr_q, ptr_d;
  logic [IdxBits-1:0]  best_q, best_d;
  logic                found_q, found_d;
  logic [SB-1:0]       bscore_q, bscore_d;
  logic [EntBits-1:0]  taken_q, taken_d;
  logic                pipe_q;           // read data valid for scan and sweep
  logic [IdxBits-1:0]  pidx_q;

  // output register
  logic                oval_q, oval_d;
  logic [EntBits-1:0]  oent_q;
  logic                olast_q;

  // sweep arithmetic stage registers and compare terms
  logic                s1_q;
  logic [IdxBits-1:0]  s1_idx_q;
  logic [AB-1:0]       s1_inter_q, s1_den_q;
  logic                s1_neg_q;
  logic [AB+SB-1:0]    s2_lhs, s2_rhs;

  logic [SB-1:0]       rscore;
  logic [CoordBits-1:0] ax, ay, aw, ah, bx, by, bw, bh;

  assign rscore = rdata_i[SB-1:0];
  assign {ax, ay, aw, ah} = taken_q[EntBits-1:SB];
  assign {bx, by, bw, bh} = rdata_i[EntBits-1:SB];

  // span with the +1 rule, clamped at zero
  function automatic logic [EB:0] span(input logic [CoordBits-1:0] a1,
                                       input logic [CoordBits-1:0] al,
                                       input logic [CoordBits-1:0] b1,
                                       input logic [CoordBits-1:0] bl);
    logic [EB:0] lo, hi, a2, b2;
    logic signed [EB+1:0] s;
    a2 = (EB+1)'(a1) + (EB+1)'(al);
    b2 = (EB+1)'(b1) + (EB+1)'(bl);
    lo = (a1 > b1) ? (EB+1)'(a1) : (EB+1)'(b1);
    hi = (a2 < b2) ? a2 : b2;
    s  = $signed({1'b0, hi}) - $signed({1'b0, lo}) + $signed((EB+2)'(1));
    span = (s > 0) ? s[EB:0] : '0;
  endfunction

  logic [EB:0] sx, sy;
  logic [AB-1:0] inter, area_a, area_b;
  logic signed [AB+1:0] den_u;

  assign sx     = span(ax, aw, bx, bw);
  assign sy     = span(ay, ah, by, bh);
  assign inter  = AB'(sx * sy);
  assign area_a = AB'(aw * ah);
  assign area_b = AB'(bw * bh);
  assign den_u  = $signed({2'b0, area_a}) + $signed({2'b0, area_b})
                - $signed({2'b0, inter});

  // stage two compare, inter * 65536 against threshold * den
  assign s2_lhs = {s1_inter_q, 16'h0};
  assign s2_rhs = (AB+SB)'(thr_i * s1_den_q);

  logic kill;
  always_comb begin
    if (s1_neg_q) kill = 1'b0;
    else if (s1_den_q == '0) kill = (s1_inter_q != '0);
    else kill = s2_lhs > s2_rhs;
  end

  // sequencer: scan for best, fetch it, sweep all, emit; back to idle when none is left
  always_comb begin
    st_d     = st_q;
    alive_d  = alive_q;
    ptr_d    = ptr_q;
    best_d   = best_q;
    found_d  = found_q;
    bscore_d = bscore_q;
    taken_d  = taken_q;
    oval_d   = oval_q && !out_ready_i;
    raddr_o  = ptr_q[IdxBits-1:0];
    if (s1_q && kill) alive_d[s1_idx_q] = 1'b0;
    unique case (st_q)
      bnms_pkg::ST_IDLE: begin
        if (set_valid_i) begin
          alive_d = new_alive_i;
          ptr_d   = '0;
          found_d = 1'b0;
          st_d    = bnms_pkg::ST_SCAN;
        end
      end
      bnms_pkg::ST_SCAN: begin
        if (pipe_q && alive_q[pidx_q] &&
            (!found_q || rscore > bscore_q)) begin
          found_d  = 1'b1;
          best_d   = pidx_q;
          bscore_d = rscore;
        end
        if (ptr_q < cnt_q) ptr_d = ptr_q + 1'b1;
        else if (!pipe_q) st_d = bnms_pkg::ST_FETCH;
      end
      bnms_pkg::ST_FETCH: begin
        if (!found_q) st_d = bnms_pkg::ST_IDLE;
        else begin
          raddr_o = best_q;
          alive_d[best_q] = 1'b0;
          st_d = bnms_pkg::ST_WAITRD;
        end
      end
      bnms_pkg::ST_WAITRD: begin
        raddr_o = best_q;
        taken_d = rdata_i;
        ptr_d   = '0;
        st_d    = bnms_pkg::ST_SWEEP;
      end
      bnms_pkg::ST_SWEEP: begin
        if (ptr_q < cnt_q) ptr_d = ptr_q + 1'b1;
        else if (!pipe_q && !s1_q) st_d = bnms_pkg::ST_EMIT;
      end
      bnms_pkg::ST_EMIT: begin
        if (!oval_q || out_ready_i) begin
          oval_d  = 1'b1;
          ptr_d   = '0;
          found_d = 1'b0;
          st_d    = bnms_pkg::ST_SCAN;
        end
      end
      default: st_d = bnms_pkg::ST_IDLE;
    endcase
  end

  assign set_ready_o = (st_q == bnms_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= bnms_pkg::ST_IDLE;
      alive_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      ptr_q   <= '0;
      found_q <= 1'b0;
      pipe_q  <= 1'b0;
      s1_q    <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      alive_q <= alive_d;
      ptr_q   <= ptr_d;
      found_q <= found_d;
      oval_q  <= oval_d;
      if (st_q == bnms_pkg::ST_IDLE && set_valid_i) begin
        cnt_q <= set_info_i.count[IdxBits:0];
        ovf_q <= set_info_i.overflow;
      end
      pipe_q <= (st_q == bnms_pkg::ST_SCAN || st_q == bnms_pkg::ST_SWEEP)
                && ptr_q < cnt_q;
      s1_q   <= pipe_q && st_q == bnms_pkg::ST_SWEEP && alive_q[pidx_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    bscore_q   <= bscore_d;
    taken_q    <= taken_d;
    pidx_q     <= ptr_q[IdxBits-1:0];
    s1_idx_q   <= pidx_q;
    s1_inter_q <= inter;
    s1_neg_q   <= 1'b0;
    if (mode_i) s1_den_q <= (area_a < area_b) ? area_a : area_b;
    else begin
      s1_den_q <= den_u[AB-1:0];
      s1_neg_q <= den_u < 0;
    end
    if (st_q == bnms_pkg::ST_EMIT && (!oval_q || out_ready_i)) begin
      oent_q  <= taken_q;
      // last kept box when no live box remains
      olast_q <= (alive_q == '0);
    end
  end

  logic ovf_out_q;
  always_ff @(posedge clk_i) begin
    if (st_q == bnms_pkg::ST_EMIT && (!oval_q || out_ready_i)) ovf_out_q <= ovf_q;
  end

  assign out_valid_o = oval_q;
  assign out_entry_o = oent_q;
  assign out_last_o  = olast_q;
  assign out_ovf_o   = ovf_out_q;

  `NMS_ASSERT_IMP(a_idle_no_out_pend, clk_i, rst_ni, st_q == bnms_pkg::ST_EMIT,
    found_q, "emit without a taken box")
  `NMS_ASSERT_NEXT(a_taken_dead, clk_i, rst_ni, st_q == bnms_pkg::ST_FETCH && found_q,
    !alive_q[best_q], "taken box still live")
  `NMS_ASSERT_IMP(a_ptr_bound, clk_i, rst_ni, 1'b1, ptr_q <= cnt_q, "pointer past set")

endmodule
